[design/gdr_pkg.sv]
// Shared constants, widths and codes for the grid DDA ray caster.
package gdr_pkg;

    localparam int GRID_DIM_DEF  = 64;
    localparam int CELL_BITS_DEF = 8;

    localparam int CELL_W = 14;     // signed cell coordinate during a walk
    localparam int DIST_W = 35;     // unsigned Q.16 distance

    localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [9:0] MAX_DIST_RST    = 10'd100;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MAX_DIST    = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

endpackage

[design/gdr_grid_ram.sv]
// Tile grid memory: one write port, one read port with registered read data.
module gdr_grid_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/grid_dda_ray_cast_top.sv]
// Grid DDA ray caster top level: tile grid, cast sequencer and stream ports.
//
// After reset the grid is cleared one cell per cycle, GRID_DIM*GRID_DIM cells
// (4096 at the default size), and no item is taken meanwhile. A write item
// whose cell lies in the grid is written to it as the item is accepted. A cast
// runs on one shared subtract/compare unit and one shared 17x35 multiplier
// under a sequencer: squaring (S_SQX, S_SQY, S_SQSUM), square root (S_SQRT),
// division per axis (S_DIVINIT, S_DIV), border setup (S_LENX, S_LENY, S_LENEND),
// the cell walk (S_WALK, S_TEST; one grid memory read per cell visited, up to
// about 2*max_distance+2 cells) and the end point (S_ENDX, S_ENDY, S_ENDSUM, S_OUT).
module grid_dda_ray_cast_top #(
    parameter int GRID_DIM  = gdr_pkg::GRID_DIM_DEF,
    parameter int CELL_BITS = gdr_pkg::CELL_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [9:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cell_col[5:0] cell_row[11:6] cell_value[19:12] origin_x[43:20]
    // origin_y[67:44] heading_x[83:68] heading_y[99:84], zero fill
    input  logic [103:0] s_axis_tdata,
    // cmd[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit[0] end_x[26:1] end_y[52:27] hit_col[58:53] hit_row[64:59], zero fill
    output logic [71:0]  m_axis_tdata
);

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int MW    = $clog2(DEPTH);
    localparam int AW    = $clog2(GRID_DIM);
    localparam int CW    = gdr_pkg::CELL_W;
    localparam int DW    = gdr_pkg::DIST_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SQX, S_SQY, S_SQSUM, S_SQRT, S_DIVINIT, S_DIV,
        S_LENX, S_LENY, S_LENEND, S_WALK, S_TEST, S_ENDX, S_ENDY, S_ENDSUM, S_OUT
    } t_state;

    t_state r_state;
    logic [MW-1:0]  r_clr;
    logic [4:0]     r_cnt;
    logic           r_axis;
    logic [23:0]    r_ox, r_oy;
    logic [15:0]    r_hx, r_hy;
    logic [51:0]    r_prod;
    logic [63:0]    r_rad;
    logic [35:0]    r_rem;
    logic [31:0]    r_root;
    logic [31:0]    r_quo;
    logic [15:0]    r_drem;
    logic [31:0]    r_stx, r_sty;
    logic           r_nx, r_ny, r_dinf, r_inb, r_found;
    logic [DW-1:0]  r_rx, r_ry, r_dist;
    logic [CW-1:0]  r_cx, r_cy;
    logic [5:0]     r_hit_col, r_hit_row;
    logic [25:0]    r_endx, r_endy;
    logic [6:0]     r_gw, r_gh;
    logic [9:0]     r_maxd;
    logic           r_ovalid;
    logic [71:0]    r_odata;

    logic [15:0]    ax, ay, ad;
    logic [35:0]    alu_a, alu_b, alu_diff;
    logic           alu_ge;
    logic [16:0]    mul_a;
    logic [DW-1:0]  mul_b;
    logic [51:0]    mul_p;
    logic           accept;
    logic           wr_ok;
    logic           mem_we;
    logic [MW-1:0]  mem_waddr, mem_raddr;
    logic [CELL_BITS-1:0] mem_wdata, mem_rdata;
    logic [DW-1:0]  limit;
    logic           walk_done, take_x;
    logic [CW-1:0]  n_cx, n_cy, w_lim, h_lim;
    logic           n_inb;
    logic [15:0]    frac_x, frac_y;

    function automatic logic [25:0] end_coord(input logic [23:0] org, input logic neg,
                                              input logic [51:0] p);
        logic [37:0] m;
        logic signed [39:0] q;
        logic signed [39:0] s;
        m = neg ? 38'((p[50:0] + 51'd16383) >> 14) : 38'(p[50:0] >> 14);
        q = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
        s = 40'($signed(org)) + q;
        if (s > 40'sd33554431) begin
            end_coord = 26'h1FFFFFF;
        end else if (s < -40'sd33554432) begin
            end_coord = 26'h2000000;
        end else begin
            end_coord = s[25:0];
        end
    endfunction

    assign ax = r_hx[15] ? 16'(-r_hx) : r_hx;
    assign ay = r_hy[15] ? 16'(-r_hy) : r_hy;
    assign ad = r_axis ? ay : ax;
    assign frac_x = r_ox[15:0];
    assign frac_y = r_oy[15:0];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign wr_ok = (32'(s_axis_tdata[5:0]) < GRID_DIM) && (32'(s_axis_tdata[11:6]) < GRID_DIM);

    // shared subtract/compare unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (r_state)
            S_SQRT: begin
                alu_a = {r_rem[33:0], r_rad[63:62]};
                alu_b = {2'b00, r_root, 2'b01};
            end
            S_DIV: begin
                alu_a = {19'd0, r_drem, r_quo[31]};
                alu_b = {20'd0, ad};
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end
    assign alu_diff = alu_a - alu_b;
    assign alu_ge   = (alu_a >= alu_b);

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQX:  begin mul_a = {1'b0, ax}; mul_b = DW'(ax); end
            S_SQY:  begin mul_a = {1'b0, ay}; mul_b = DW'(ay); end
            S_LENX: begin
                mul_a = r_hx[15] ? {1'b0, frac_x} : 17'h10000 - {1'b0, frac_x};
                mul_b = DW'(r_stx);
            end
            S_LENY: begin
                mul_a = r_hy[15] ? {1'b0, frac_y} : 17'h10000 - {1'b0, frac_y};
                mul_b = DW'(r_sty);
            end
            S_ENDX: begin mul_a = {1'b0, ax}; mul_b = r_dist; end
            S_ENDY: begin mul_a = {1'b0, ay}; mul_b = r_dist; end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = 52'(mul_a) * 52'(mul_b);

    // walk step
    assign limit     = DW'({r_maxd, 16'd0});
    assign walk_done = r_dinf || (r_dist >= limit);
    assign take_x    = !r_nx && (r_ny || (r_rx < r_ry));
    assign w_lim = (32'(r_gw) > GRID_DIM) ? CW'(GRID_DIM) : CW'(r_gw);
    assign h_lim = (32'(r_gh) > GRID_DIM) ? CW'(GRID_DIM) : CW'(r_gh);

    always_comb begin
        n_cx = r_cx;
        n_cy = r_cy;
        if (take_x) begin
            n_cx = r_hx[15] ? r_cx - CW'(1) : r_cx + CW'(1);
        end else if (!r_ny) begin
            n_cy = r_hy[15] ? r_cy - CW'(1) : r_cy + CW'(1);
        end
    end
    assign n_inb = !n_cx[CW-1] && !n_cy[CW-1] && (n_cx < w_lim) && (n_cy < h_lim);
    assign mem_raddr = MW'(n_cy[AW-1:0]) * MW'(GRID_DIM) + MW'(n_cx[AW-1:0]);

    assign mem_we    = (r_state == S_CLEAR) ||
                       (accept && (s_axis_tuser == gdr_pkg::CMD_WRITE) && wr_ok);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr :
                       MW'(s_axis_tdata[11:6]) * MW'(GRID_DIM) + MW'(s_axis_tdata[5:0]);
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : CELL_BITS'(s_axis_tdata[19:12]);

    gdr_grid_ram #(
        .DEPTH (DEPTH),
        .AW    (MW),
        .DW    (CELL_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= gdr_pkg::GRID_WIDTH_RST;
            r_gh   <= gdr_pkg::GRID_HEIGHT_RST;
            r_maxd <= gdr_pkg::MAX_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gdr_pkg::CFG_GRID_WIDTH:  r_gw   <= i_cfg_data[6:0];
                gdr_pkg::CFG_GRID_HEIGHT: r_gh   <= i_cfg_data[6:0];
                gdr_pkg::CFG_MAX_DIST:    r_maxd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_hit_col <= '0;
            r_hit_row <= '0;
            r_found   <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MW'(1);
                    if (r_clr == MW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && (s_axis_tuser == gdr_pkg::CMD_CAST)) begin
                        r_ox    <= s_axis_tdata[43:20];
                        r_oy    <= s_axis_tdata[67:44];
                        r_hx    <= s_axis_tdata[83:68];
                        r_hy    <= s_axis_tdata[99:84];
                        r_cx    <= CW'($signed(s_axis_tdata[43:36]));
                        r_cy    <= CW'($signed(s_axis_tdata[67:60]));
                        r_nx    <= 1'b0;
                        r_ny    <= 1'b0;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_rad   <= {r_prod[31:0], 32'd0};
                    r_state <= S_SQSUM;
                end
                S_SQSUM: begin
                    r_rad   <= {r_rad[63:32] + r_prod[31:0], 32'd0};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rem  <= alu_ge ? alu_diff : alu_a;
                    r_root <= {r_root[30:0], alu_ge};
                    r_rad  <= {r_rad[61:0], 2'b00};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_axis  <= 1'b0;
                        r_state <= S_DIVINIT;
                    end
                end
                S_DIVINIT: begin
                    r_quo  <= r_root;
                    r_drem <= '0;
                    r_cnt  <= '0;
                    if (ad == 16'd0) begin
                        if (r_axis) begin
                            r_ny    <= 1'b1;
                            r_state <= S_LENX;
                        end else begin
                            r_nx    <= 1'b1;
                            r_axis  <= 1'b1;
                        end
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= alu_ge ? alu_diff[15:0] : alu_a[15:0];
                    r_quo  <= {r_quo[30:0], alu_ge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        if (r_axis) begin
                            r_sty   <= {r_quo[30:0], alu_ge};
                            r_state <= S_LENX;
                        end else begin
                            r_stx   <= {r_quo[30:0], alu_ge};
                            r_axis  <= 1'b1;
                            r_state <= S_DIVINIT;
                        end
                    end
                end
                S_LENX: r_state <= S_LENY;
                S_LENY: begin
                    r_rx    <= DW'(r_prod[48:16]);
                    r_state <= S_LENEND;
                end
                S_LENEND: begin
                    r_ry    <= DW'(r_prod[48:16]);
                    r_dist  <= '0;
                    r_dinf  <= 1'b0;
                    r_found <= 1'b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (walk_done) begin
                        r_dist  <= limit;
                        r_state <= S_ENDX;
                    end else begin
                        if (take_x) begin
                            r_dist <= r_rx;
                            r_rx   <= r_rx + DW'(r_stx);
                        end else if (r_ny) begin
                            r_dinf <= 1'b1;
                        end else begin
                            r_dist <= r_ry;
                            r_ry   <= r_ry + DW'(r_sty);
                        end
                        r_cx    <= n_cx;
                        r_cy    <= n_cy;
                        r_inb   <= n_inb;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_inb && (mem_rdata >= CELL_BITS'(1)) && (mem_rdata <= CELL_BITS'(3)))
                    begin
                        r_found   <= 1'b1;
                        r_hit_col <= r_cx[5:0];
                        r_hit_row <= r_cy[5:0];
                        r_state   <= S_ENDX;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_ENDX: r_state <= S_ENDY;
                S_ENDY: begin
                    r_endx  <= end_coord(r_ox, r_hx[15], r_prod);
                    r_state <= S_ENDSUM;
                end
                S_ENDSUM: begin
                    r_endy  <= end_coord(r_oy, r_hy[15], r_prod);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_hit_row, r_hit_col, r_endy, r_endx, r_found};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    a_test_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST) && r_inb |-> !r_cx[CW-1] && !r_cy[CW-1])
        else $error("grid read outside grid");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result loaded outside output state");

    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> ({1'b0, r_root} < (33'd1 << r_cnt)))
        else $error("square root grew too fast");

endmodule
